// ===== rtl/core/lfss_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helpers for the line-follow steering/speed block.
// Used by every module under rtl/core; depends on nothing.
package lfss_pkg;

    localparam int SENSOR_COUNT    = 5;
    localparam int SAMPLE_BITS     = 10;
    localparam int PWM_MAX         = 255;

    localparam int WHITE_BITS      = 10;
    localparam int DB_BITS         = 10;
    localparam int KP_BITS         = 12;
    localparam int SERVO_BITS      = 24;
    localparam int ANGLE_BITS      = 8;
    localparam int PWM_BITS        = 8;
    localparam int RATIO_BITS      = 8;
    localparam int TH_BITS         = 10;
    localparam int TURN_SHIFT      = 6;
    localparam int SLOW_SHIFT      = 7;
    localparam int FRAC_BITS       = 8;
    localparam int ANGLE_FRAC      = 12;
    localparam int PROD_BITS       = PWM_BITS + RATIO_BITS;

    localparam int SENSOR_IDX_BITS = $clog2(SENSOR_COUNT);
    localparam int DARK_BITS       = ((WHITE_BITS > SAMPLE_BITS) ? WHITE_BITS : SAMPLE_BITS) + 1;
    localparam int SUM_BITS        = WHITE_BITS + SENSOR_IDX_BITS;
    localparam int W_BITS          = WHITE_BITS + SENSOR_IDX_BITS;
    localparam int NUM_BITS        = W_BITS + FRAC_BITS;
    localparam int Q_BITS          = FRAC_BITS + 2;
    localparam int ERR_BITS        = Q_BITS + 1;
    localparam int ERR_MAX         = 2 << FRAC_BITS;
    localparam int TRIAL_BITS      = SUM_BITS + Q_BITS;
    localparam int KPQ_BITS        = KP_BITS + Q_BITS;
    localparam int ANG_BITS        = KPQ_BITS + 2;

    // |error| < 0.15 in Q2.8 is |error| * 20 < 768
    localparam int STRAIGHT_NUM    = 768;
    localparam int STRAIGHT_DEN    = 20;
    localparam int STRAIGHT_LIM    = (STRAIGHT_NUM + STRAIGHT_DEN - 1) / STRAIGHT_DEN;
    localparam int RATIO_ONE       = 1 << SLOW_SHIFT;

    localparam int IN_BITS         = SENSOR_COUNT * SAMPLE_BITS;
    localparam int IN_TDATA_BITS   = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS        = ANGLE_BITS + 2 * PWM_BITS + ERR_BITS + 2;
    localparam int OUT_TDATA_BITS  = ((OUT_BITS + 7) / 8) * 8;

    localparam int CFG_INDEX_BITS  = 4;
    localparam int CFG_DATA_BITS   = SENSOR_COUNT * WHITE_BITS;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_WHITE      = 4'd0,
        CFG_DEADBAND   = 4'd1,
        CFG_KP         = 4'd2,
        CFG_SERVO      = 4'd3,
        CFG_BASE       = 4'd4,
        CFG_TURN       = 4'd5,
        CFG_SLOW_TH    = 4'd6,
        CFG_SLOW_RATIO = 4'd7
    } cfg_index_t;

    localparam logic [DB_BITS-1:0]         DEADBAND_RESET   = 10'd50;
    localparam logic [KP_BITS-1:0]         KP_RESET         = 12'd320;
    localparam logic [SERVO_BITS-1:0]      SERVO_RESET      = 24'h872D5A;
    localparam logic [PWM_BITS-1:0]        BASE_RESET       = 8'd150;
    localparam logic [2*RATIO_BITS-1:0]    TURN_RESET       = 16'h5030;
    localparam logic [2*TH_BITS-1:0]       SLOW_TH_RESET    = 20'h600CD;
    localparam logic [2*RATIO_BITS-1:0]    SLOW_RATIO_RESET = 16'h4D66;

    localparam logic signed [3:0] SENSOR_POS [SENSOR_COUNT] = '{-4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2};

    typedef enum logic [1:0] {
        SLOW_NONE = 2'd0,
        SLOW_ONE  = 2'd1,
        SLOW_TWO  = 2'd2
    } slow_level_t;

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0]   white;
        logic [DB_BITS-1:0]         deadband;
        logic [KP_BITS-1:0]         kp;
        logic [SERVO_BITS-1:0]      servo;
        logic [PWM_BITS-1:0]        base;
        logic [2*RATIO_BITS-1:0]    turn;
        logic [2*TH_BITS-1:0]       slow_th;
        logic [2*RATIO_BITS-1:0]    slow_ratio;
    } cfg_t;

    typedef logic [SENSOR_COUNT-1:0][WHITE_BITS-1:0] dark_vec_t;

    typedef struct packed {
        logic                   seen;
        logic                   neg;
        logic [NUM_BITS-1:0]    rem;
        logic [SUM_BITS-1:0]    den;
        logic [Q_BITS-1:0]      quo;
    } div_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0]      angle;
        logic [PWM_BITS-1:0]        left;
        logic [PWM_BITS-1:0]        right;
        logic signed [ERR_BITS-1:0] err;
        logic                       seen;
        slow_level_t                level;
    } res_t;

    function automatic logic [PWM_BITS-1:0] sat_pwm(input logic [PROD_BITS-1:0] v);
        return (v > PROD_BITS'(PWM_MAX)) ? PWM_BITS'(PWM_MAX) : PWM_BITS'(v);
    endfunction

endpackage

// ===== rtl/core/lfss_lane.sv =====
`timescale 1ns / 1ps
// One sensor lane: darkness against the white level, deadband test, registered.
// Depends on lfss_pkg.
module lfss_lane (
    input  logic                                aclk,
    input  logic                                en,
    input  logic [lfss_pkg::WHITE_BITS-1:0]     white,
    input  logic [lfss_pkg::SAMPLE_BITS-1:0]    sample,
    input  logic [lfss_pkg::DB_BITS-1:0]        deadband,
    output logic [lfss_pkg::WHITE_BITS-1:0]     dark
);

    logic signed [lfss_pkg::DARK_BITS-1:0] diff;
    logic                                  pass;
    logic [lfss_pkg::WHITE_BITS-1:0]       dark_reg;
    logic [lfss_pkg::WHITE_BITS-1:0]       dark_next;

    assign diff = $signed(lfss_pkg::DARK_BITS'(white)) - $signed(lfss_pkg::DARK_BITS'(sample));
    assign pass = diff >= $signed(lfss_pkg::DARK_BITS'(deadband));
    // a passing darkness is never above the white level, so it fits WHITE_BITS
    assign dark_next = pass ? diff[lfss_pkg::WHITE_BITS-1:0] : '0;

    always_ff @(posedge aclk) begin
        if (en) begin
            dark_reg <= dark_next;
        end
    end

    assign dark = dark_reg;

endmodule

// ===== rtl/core/lfss_merge.sv =====
`timescale 1ns / 1ps
// Merge of the lane results: weighted sum, weight total, divider operands.
// Depends on lfss_pkg.
module lfss_merge (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  lfss_pkg::dark_vec_t dark,
    output logic                out_valid,
    output lfss_pkg::div_t      out_data
);

    logic signed [lfss_pkg::W_BITS-1:0] wsum;
    logic [lfss_pkg::SUM_BITS-1:0]      tsum;
    logic [lfss_pkg::W_BITS-1:0]        wabs;
    lfss_pkg::div_t                     data_next;
    lfss_pkg::div_t                     data_reg;
    logic                               vld_reg;

    always_comb begin
        wsum = '0;
        tsum = '0;
        for (int i = 0; i < lfss_pkg::SENSOR_COUNT; i++) begin
            tsum = tsum + lfss_pkg::SUM_BITS'(dark[i]);
            wsum = wsum + $signed(lfss_pkg::W_BITS'(dark[i]))
                        * lfss_pkg::W_BITS'(lfss_pkg::SENSOR_POS[i]);
        end
        wabs = (wsum < 0) ? lfss_pkg::W_BITS'(-wsum) : lfss_pkg::W_BITS'(wsum);

        data_next.seen = (tsum != '0);
        data_next.neg  = (wsum < 0);
        data_next.rem  = lfss_pkg::NUM_BITS'(wabs) << lfss_pkg::FRAC_BITS;
        data_next.den  = tsum;
        data_next.quo  = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/core/lfss_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// Depends on lfss_pkg.
module lfss_div (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  lfss_pkg::div_t  in_data,
    output logic            out_valid,
    output lfss_pkg::div_t  out_data
);

    lfss_pkg::div_t st_reg  [lfss_pkg::Q_BITS];
    logic           vld_reg [lfss_pkg::Q_BITS];

    for (genvar s = 0; s < lfss_pkg::Q_BITS; s++) begin : g_stage
        localparam int K = lfss_pkg::Q_BITS - 1 - s;

        lfss_pkg::div_t                  cur;
        lfss_pkg::div_t                  st_next;
        logic                            cur_vld;
        logic [lfss_pkg::TRIAL_BITS-1:0] trial;
        logic                            take;

        if (s == 0) begin : g_first
            assign cur     = in_data;
            assign cur_vld = in_valid;
        end else begin : g_rest
            assign cur     = st_reg[s-1];
            assign cur_vld = vld_reg[s-1];
        end

        always_comb begin
            trial   = lfss_pkg::TRIAL_BITS'(cur.den) << K;
            take    = lfss_pkg::TRIAL_BITS'(cur.rem) >= trial;
            st_next = cur;
            if (take) begin
                st_next.rem    = cur.rem - lfss_pkg::NUM_BITS'(trial);
                st_next.quo[K] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= cur_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[s] <= st_next;
            end
        end
    end

    assign out_valid = vld_reg[lfss_pkg::Q_BITS-1];
    assign out_data  = st_reg[lfss_pkg::Q_BITS-1];

endmodule

// ===== rtl/core/lfss_ctrl.sv =====
`timescale 1ns / 1ps
// Steering and wheel-speed back end: signed error, P term, clamp, turn and slow scaling.
// Two register stages; depends on lfss_pkg.
module lfss_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  lfss_pkg::cfg_t  cfg,
    input  logic            in_valid,
    input  lfss_pkg::div_t  in_data,
    output logic            out_valid,
    output lfss_pkg::res_t  out_data
);

    // first stage
    logic [lfss_pkg::Q_BITS-1:0]          q;
    logic                                 neg;
    logic                                 pos;
    logic                                 straight;
    logic [lfss_pkg::PROD_BITS-1:0]       prod_in;
    logic [lfss_pkg::PROD_BITS-1:0]       prod_out;
    logic [lfss_pkg::PWM_BITS-1:0]        spd_in;
    logic [lfss_pkg::PWM_BITS-1:0]        spd_out;
    logic [lfss_pkg::PWM_BITS-1:0]        spd_base;
    logic [lfss_pkg::TH_BITS-1:0]         th1;
    logic [lfss_pkg::TH_BITS-1:0]         th2;

    logic                                 p1_vld_reg;
    logic [lfss_pkg::KPQ_BITS-1:0]        p1_kpq_reg,   p1_kpq_next;
    logic                                 p1_neg_reg;
    logic signed [lfss_pkg::ERR_BITS-1:0] p1_err_reg,   p1_err_next;
    logic                                 p1_seen_reg;
    logic [lfss_pkg::PWM_BITS-1:0]        p1_left_reg,  p1_left_next;
    logic [lfss_pkg::PWM_BITS-1:0]        p1_right_reg, p1_right_next;
    logic [lfss_pkg::RATIO_BITS-1:0]      p1_ratio_reg, p1_ratio_next;
    lfss_pkg::slow_level_t                p1_level_reg, p1_level_next;

    // second stage
    logic signed [lfss_pkg::ANG_BITS-1:0] term;
    logic signed [lfss_pkg::ANG_BITS-1:0] ang;
    logic signed [lfss_pkg::ANG_BITS-1:0] ang_lo;
    logic signed [lfss_pkg::ANG_BITS-1:0] ang_hi;
    logic signed [lfss_pkg::ANG_BITS-1:0] ang_c;
    logic [lfss_pkg::PROD_BITS-1:0]       slow_l;
    logic [lfss_pkg::PROD_BITS-1:0]       slow_r;
    logic                                 res_vld_reg;
    lfss_pkg::res_t                       res_reg, res_next;

    always_comb begin
        q   = in_data.seen ? in_data.quo : '0;
        neg = in_data.seen && in_data.neg;
        pos = !neg && (q != '0);

        p1_err_next = neg ? -$signed(lfss_pkg::ERR_BITS'(q)) : $signed(lfss_pkg::ERR_BITS'(q));
        p1_kpq_next = lfss_pkg::KPQ_BITS'(cfg.kp) * lfss_pkg::KPQ_BITS'(q);

        straight = q < lfss_pkg::Q_BITS'(lfss_pkg::STRAIGHT_LIM);
        prod_in  = lfss_pkg::PROD_BITS'(cfg.base)
                 * lfss_pkg::PROD_BITS'(cfg.turn[lfss_pkg::RATIO_BITS-1:0]);
        prod_out = lfss_pkg::PROD_BITS'(cfg.base)
                 * lfss_pkg::PROD_BITS'(cfg.turn[2*lfss_pkg::RATIO_BITS-1:lfss_pkg::RATIO_BITS]);
        spd_in   = lfss_pkg::sat_pwm(prod_in >> lfss_pkg::TURN_SHIFT);
        spd_out  = lfss_pkg::sat_pwm(prod_out >> lfss_pkg::TURN_SHIFT);
        spd_base = lfss_pkg::sat_pwm(lfss_pkg::PROD_BITS'(cfg.base));

        if (straight) begin
            p1_left_next  = spd_base;
            p1_right_next = spd_base;
        end else if (pos) begin
            p1_left_next  = spd_in;
            p1_right_next = spd_out;
        end else begin
            p1_left_next  = spd_out;
            p1_right_next = spd_in;
        end

        th1 = cfg.slow_th[lfss_pkg::TH_BITS-1:0];
        th2 = cfg.slow_th[2*lfss_pkg::TH_BITS-1:lfss_pkg::TH_BITS];
        if (q > th2) begin
            p1_ratio_next = cfg.slow_ratio[2*lfss_pkg::RATIO_BITS-1:lfss_pkg::RATIO_BITS];
            p1_level_next = lfss_pkg::SLOW_TWO;
        end else if (q > th1) begin
            p1_ratio_next = cfg.slow_ratio[lfss_pkg::RATIO_BITS-1:0];
            p1_level_next = lfss_pkg::SLOW_ONE;
        end else begin
            p1_ratio_next = lfss_pkg::RATIO_BITS'(lfss_pkg::RATIO_ONE);
            p1_level_next = lfss_pkg::SLOW_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
        end else if (en) begin
            p1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_kpq_reg   <= p1_kpq_next;
            p1_neg_reg   <= neg;
            p1_err_reg   <= p1_err_next;
            p1_seen_reg  <= in_data.seen;
            p1_left_reg  <= p1_left_next;
            p1_right_reg <= p1_right_next;
            p1_ratio_reg <= p1_ratio_next;
            p1_level_reg <= p1_level_next;
        end
    end

    always_comb begin
        term   = $signed(lfss_pkg::ANG_BITS'(p1_kpq_reg));
        if (p1_neg_reg) begin
            term = -term;
        end
        ang    = $signed(lfss_pkg::ANG_BITS'({cfg.servo[7:0], {lfss_pkg::ANGLE_FRAC{1'b0}}})) + term;
        ang_lo = $signed(lfss_pkg::ANG_BITS'({cfg.servo[15:8], {lfss_pkg::ANGLE_FRAC{1'b0}}}));
        ang_hi = $signed(lfss_pkg::ANG_BITS'({cfg.servo[23:16], {lfss_pkg::ANGLE_FRAC{1'b0}}}));
        // minimum is tested first, so inverted limits resolve the same way
        if (ang < ang_lo) begin
            ang_c = ang_lo;
        end else if (ang > ang_hi) begin
            ang_c = ang_hi;
        end else begin
            ang_c = ang;
        end

        slow_l = lfss_pkg::PROD_BITS'(p1_left_reg)  * lfss_pkg::PROD_BITS'(p1_ratio_reg);
        slow_r = lfss_pkg::PROD_BITS'(p1_right_reg) * lfss_pkg::PROD_BITS'(p1_ratio_reg);

        res_next.angle = ang_c[lfss_pkg::ANGLE_FRAC +: lfss_pkg::ANGLE_BITS];
        res_next.left  = lfss_pkg::sat_pwm(slow_l >> lfss_pkg::SLOW_SHIFT);
        res_next.right = lfss_pkg::sat_pwm(slow_r >> lfss_pkg::SLOW_SHIFT);
        res_next.err   = p1_err_reg;
        res_next.seen  = p1_seen_reg;
        res_next.level = p1_level_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_vld_reg <= 1'b0;
        end else if (en) begin
            res_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = res_vld_reg;
    assign out_data  = res_reg;

endmodule

// ===== rtl/core/line_follow_steering_speed.sv =====
`timescale 1ns / 1ps
// Line-follow steering and speed: top level with config registers and output skid.
// Depends on lfss_pkg, lfss_lane, lfss_merge, lfss_div and lfss_ctrl.
//
// Usage:
//   s_* carries one beat per sensor set: five samples, far-left in the low bits.
//   m_* returns one beat per set: servo angle, both wheel duties, line error and
//   slow level in m_tdata, and the line-seen flag in m_tuser.
//   cfg_* writes one register per beat (index 0..7, higher indexes are ignored);
//   cfg_ready is always high. Write config only while the block is empty.
// Throughput: one beat per cycle. Five sensor lanes work in parallel, a merge
//   stage sums them and a 10-stage divider yields one quotient bit per stage.
// Pipeline: 15 register stages, the lane registers loading at the accepting
//   edge (lanes 1, merge 1, divider 10, steer/speed 2, output register 1).
// Reset: aresetn low clears all pipeline valids and the skid, and loads the
//   register defaults. No clearing pass; s_tready is high the cycle after.
// Stall: a two-entry skid at the output absorbs back-pressure. When its spare
//   entry fills, s_tready drops and the whole pipeline holds in place until
//   m_tready takes the waiting beat. s_tready is registered, with no path from
//   m_tready.
module line_follow_steering_speed (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // far_left [9:0], near_left [19:10], middle [29:20], near_right [39:30],
    // far_right [49:40], zero pad [55:50]
    input  logic [lfss_pkg::IN_TDATA_BITS-1:0]    s_tdata,

    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // servo_angle [7:0], left_speed [15:8], right_speed [23:16],
    // line_error [34:24], slow_level [36:35], zero pad [39:37]
    output logic [lfss_pkg::OUT_TDATA_BITS-1:0]   m_tdata,
    // line_seen [0]
    output logic                                  m_tuser,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lfss_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [lfss_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    lfss_pkg::cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                lfss_pkg::CFG_WHITE:      cfg_next.white      = cfg_data;
                lfss_pkg::CFG_DEADBAND:   cfg_next.deadband   = cfg_data[lfss_pkg::DB_BITS-1:0];
                lfss_pkg::CFG_KP:         cfg_next.kp         = cfg_data[lfss_pkg::KP_BITS-1:0];
                lfss_pkg::CFG_SERVO:      cfg_next.servo      = cfg_data[lfss_pkg::SERVO_BITS-1:0];
                lfss_pkg::CFG_BASE:       cfg_next.base       = cfg_data[lfss_pkg::PWM_BITS-1:0];
                lfss_pkg::CFG_TURN:       cfg_next.turn       = cfg_data[2*lfss_pkg::RATIO_BITS-1:0];
                lfss_pkg::CFG_SLOW_TH:    cfg_next.slow_th    = cfg_data[2*lfss_pkg::TH_BITS-1:0];
                lfss_pkg::CFG_SLOW_RATIO: cfg_next.slow_ratio = cfg_data[2*lfss_pkg::RATIO_BITS-1:0];
                default: ;  // unused index: drop the write
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.white      <= '1;
            cfg_reg.deadband   <= lfss_pkg::DEADBAND_RESET;
            cfg_reg.kp         <= lfss_pkg::KP_RESET;
            cfg_reg.servo      <= lfss_pkg::SERVO_RESET;
            cfg_reg.base       <= lfss_pkg::BASE_RESET;
            cfg_reg.turn       <= lfss_pkg::TURN_RESET;
            cfg_reg.slow_th    <= lfss_pkg::SLOW_TH_RESET;
            cfg_reg.slow_ratio <= lfss_pkg::SLOW_RATIO_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline: the whole chain advances together while the skid has room
    // ------------------------------------------------------------------
    logic                adv;
    logic                lane_vld_reg;
    lfss_pkg::dark_vec_t dark_vec;
    logic                mrg_vld;
    lfss_pkg::div_t      mrg_data;
    logic                div_vld;
    lfss_pkg::div_t      div_data;
    logic                res_vld;
    lfss_pkg::res_t      res_data;

    for (genvar i = 0; i < lfss_pkg::SENSOR_COUNT; i++) begin : g_lane
        lfss_lane u_lane (
            .aclk     (aclk),
            .en       (adv),
            .white    (cfg_reg.white[i*lfss_pkg::WHITE_BITS +: lfss_pkg::WHITE_BITS]),
            .sample   (s_tdata[i*lfss_pkg::SAMPLE_BITS +: lfss_pkg::SAMPLE_BITS]),
            .deadband (cfg_reg.deadband),
            .dark     (dark_vec[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_vld_reg <= 1'b0;
        end else if (adv) begin
            lane_vld_reg <= s_tvalid;
        end
    end

    lfss_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (lane_vld_reg),
        .dark      (dark_vec),
        .out_valid (mrg_vld),
        .out_data  (mrg_data)
    );

    lfss_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (mrg_vld),
        .in_data   (mrg_data),
        .out_valid (div_vld),
        .out_data  (div_data)
    );

    lfss_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .cfg       (cfg_reg),
        .in_valid  (div_vld),
        .in_data   (div_data),
        .out_valid (res_vld),
        .out_data  (res_data)
    );

    // ------------------------------------------------------------------
    // Output skid: head entry drives m_*, spare catches one beat on stall
    // ------------------------------------------------------------------
    lfss_pkg::res_t out_reg,   out_next;
    logic           out_vld_reg, out_vld_next;
    lfss_pkg::res_t spare_reg, spare_next;
    logic           spare_vld_reg, spare_vld_next;
    logic           push;
    logic           pop;

    assign adv      = !spare_vld_reg;
    assign s_tready = adv;
    assign push     = adv && res_vld;
    assign pop      = out_vld_reg && m_tready;

    always_comb begin
        out_next       = out_reg;
        out_vld_next   = out_vld_reg;
        spare_next     = spare_reg;
        spare_vld_next = spare_vld_reg;
        if (!out_vld_reg || pop) begin
            if (spare_vld_reg) begin
                // spare full means the pipeline held: no push this cycle
                out_next       = spare_reg;
                out_vld_next   = 1'b1;
                spare_vld_next = 1'b0;
            end else begin
                out_next       = res_data;
                out_vld_next   = push;
            end
        end else if (push) begin
            spare_next     = res_data;
            spare_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg   <= 1'b0;
            spare_vld_reg <= 1'b0;
        end else begin
            out_vld_reg   <= out_vld_next;
            spare_vld_reg <= spare_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg   <= out_next;
        spare_reg <= spare_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_reg.seen;
    assign m_tdata  = lfss_pkg::OUT_TDATA_BITS'({out_reg.level, out_reg.err, out_reg.right,
                                                 out_reg.left, out_reg.angle});

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // the spare entry only ever fills behind a held head entry
    a_spare_behind_head: assert property (@(posedge aclk) disable iff (!aresetn)
        spare_vld_reg |-> out_vld_reg)
        else $error("skid spare valid without head entry");

    // no line seen forces a zero error
    a_no_line_zero_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !out_reg.seen) |-> (out_reg.err == '0))
        else $error("nonzero line error without line");

    // centroid error stays within two sensor pitches
    a_err_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> ((out_reg.err <= $signed(lfss_pkg::ERR_BITS'(lfss_pkg::ERR_MAX)))
                      && (out_reg.err >= -$signed(lfss_pkg::ERR_BITS'(lfss_pkg::ERR_MAX)))))
        else $error("line error out of range");

endmodule

// ===== tb/steer_speed_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for line_follow_steering_speed: mirrors the registers from the config
// channel, predicts one output beat per accepted sensor beat and compares them in order.
// Depends on lfss_pkg.
module steer_speed_checker
    import lfss_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [IN_TDATA_BITS-1:0]    s_tdata,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [OUT_TDATA_BITS-1:0]   m_tdata,
    input  logic                        m_tuser,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]    cfg_data,
    output int                          cmds_outstanding,
    output int                          mismatch_count
);

    // after reset: level one at 205, level two at 384
    localparam logic [2*TH_BITS-1:0] SLOW_TH_DEFAULT = 20'd393421;
    localparam int REPORT_LIMIT = 10;

    cfg_t regs;
    res_t predicted_cmds [$];
    res_t want;

    wire [ANGLE_BITS-1:0]       got_angle = m_tdata[7:0];
    wire [PWM_BITS-1:0]         got_left  = m_tdata[15:8];
    wire [PWM_BITS-1:0]         got_right = m_tdata[23:16];
    wire signed [ERR_BITS-1:0]  got_err   = m_tdata[34:24];
    wire [1:0]                  got_level = m_tdata[36:35];
    wire [2:0]                  got_pad   = m_tdata[39:37];

    function automatic logic [PWM_BITS-1:0] clip_duty(input longint v);
        return (v > PWM_MAX) ? PWM_BITS'(PWM_MAX) : PWM_BITS'(v);
    endfunction

    function automatic res_t predict_steer_speed(input logic [IN_TDATA_BITS-1:0] beat,
                                                 input cfg_t c);
        res_t   r;
        longint dark, wsum, wtot, err, mag, ang, lo, hi;
        longint base, r_in, r_out, left, right, ratio;
        wsum = 0;
        wtot = 0;
        err  = 0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            dark = longint'(c.white[i*WHITE_BITS +: WHITE_BITS])
                 - longint'(beat[i*SAMPLE_BITS +: SAMPLE_BITS]);
            if (dark >= longint'(c.deadband)) begin
                wsum += (i - 2) * dark;
                wtot += dark;
            end
        end
        r.seen = (wtot >= 1);
        // signed division truncates toward zero
        if (r.seen)
            err = (wsum * (1 << FRAC_BITS)) / wtot;
        mag = (err < 0) ? -err : err;

        // low limit is tested first, which decides inverted limits
        lo  = longint'(c.servo[15:8]) * (1 << ANGLE_FRAC);
        hi  = longint'(c.servo[23:16]) * (1 << ANGLE_FRAC);
        ang = longint'(c.servo[7:0]) * (1 << ANGLE_FRAC) + longint'(c.kp) * err;
        if (ang < lo)
            ang = lo;
        else if (ang > hi)
            ang = hi;
        r.angle = ANGLE_BITS'(ang >>> ANGLE_FRAC);

        base  = longint'(c.base);
        r_in  = longint'(c.turn[7:0]);
        r_out = longint'(c.turn[15:8]);
        if (mag * STRAIGHT_DEN < STRAIGHT_NUM) begin
            left  = clip_duty(base);
            right = left;
        end else if (err > 0) begin
            left  = clip_duty((base * r_in) >>> TURN_SHIFT);
            right = clip_duty((base * r_out) >>> TURN_SHIFT);
        end else begin
            left  = clip_duty((base * r_out) >>> TURN_SHIFT);
            right = clip_duty((base * r_in) >>> TURN_SHIFT);
        end

        ratio   = RATIO_ONE;
        r.level = SLOW_NONE;
        if (mag > longint'(c.slow_th[19:10])) begin
            ratio   = longint'(c.slow_ratio[15:8]);
            r.level = SLOW_TWO;
        end else if (mag > longint'(c.slow_th[9:0])) begin
            ratio   = longint'(c.slow_ratio[7:0]);
            r.level = SLOW_ONE;
        end
        r.left  = clip_duty((left * ratio) >>> SLOW_SHIFT);
        r.right = clip_duty((right * ratio) >>> SLOW_SHIFT);
        r.err   = ERR_BITS'(err);
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            regs.white      = '1;
            regs.deadband   = DEADBAND_RESET;
            regs.kp         = KP_RESET;
            regs.servo      = SERVO_RESET;
            regs.base       = BASE_RESET;
            regs.turn       = TURN_RESET;
            regs.slow_th    = SLOW_TH_DEFAULT;
            regs.slow_ratio = SLOW_RATIO_RESET;
            predicted_cmds.delete();
            mismatch_count = 0;
            cmds_outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_WHITE:      regs.white      = cfg_data;
                    CFG_DEADBAND:   regs.deadband   = cfg_data[DB_BITS-1:0];
                    CFG_KP:         regs.kp         = cfg_data[KP_BITS-1:0];
                    CFG_SERVO:      regs.servo      = cfg_data[SERVO_BITS-1:0];
                    CFG_BASE:       regs.base       = cfg_data[PWM_BITS-1:0];
                    CFG_TURN:       regs.turn       = cfg_data[2*RATIO_BITS-1:0];
                    CFG_SLOW_TH:    regs.slow_th    = cfg_data[2*TH_BITS-1:0];
                    CFG_SLOW_RATIO: regs.slow_ratio = cfg_data[2*RATIO_BITS-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
                predicted_cmds.push_back(predict_steer_speed(s_tdata, regs));

            if (m_tvalid && m_tready) begin
                if (predicted_cmds.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: output beat with nothing predicted, tdata %h tuser %b",
                                 $realtime, m_tdata, m_tuser);
                end else begin
                    want = predicted_cmds.pop_front();
                    if (got_angle !== want.angle || got_left !== want.left ||
                        got_right !== want.right || got_err !== want.err ||
                        m_tuser !== want.seen || got_level !== want.level ||
                        got_pad !== 3'b000) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $write("%0t: mismatch (expected/actual) angle %0d/%0d ",
                                   $realtime, want.angle, got_angle);
                            $write("left %0d/%0d right %0d/%0d error %0d/%0d ",
                                   want.left, got_left, want.right, got_right,
                                   want.err, got_err);
                            $display("seen %b/%b level %0d/%0d pad 000/%b",
                                     want.seen, m_tuser, want.level, got_level, got_pad);
                        end
                    end
                end
            end
            cmds_outstanding <= predicted_cmds.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the line_follow_steering_speed testbench: clock, reset, stimulus and verdict.
// Depends on lfss_pkg, line_follow_steering_speed and steer_speed_checker.
module testbench;
    import lfss_pkg::*;

    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 250;
    // margin for the pipeline and the output skid to settle
    localparam int DRAIN_MARGIN    = 20;
    // indexes past the register list; writes there must change nothing
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 4'd8;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 4'd15;

    logic                       aclk;
    logic                       aresetn   = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [IN_TDATA_BITS-1:0]   s_tdata   = '0;
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [OUT_TDATA_BITS-1:0]  m_tdata;
    logic                       m_tuser;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]   cfg_data  = '0;
    int                         cmds_outstanding;
    int                         mismatch_count;

    // calm: no sender gaps and no receiver stalls
    bit                         calm = 1'b0;
    // stimulus-side copy of white levels and deadband, used to aim the samples
    logic [CFG_DATA_BITS-1:0]   cur_white = '1;
    logic [DB_BITS-1:0]         cur_db    = DEADBAND_RESET;

    line_follow_steering_speed dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        // far_left [9:0], near_left [19:10], middle [29:20], near_right [39:30],
        // far_right [49:40], zero pad [55:50]
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        // servo_angle [7:0], left_speed [15:8], right_speed [23:16],
        // line_error [34:24], slow_level [36:35], zero pad [39:37]
        .m_tdata   (m_tdata),
        // line_seen [0]
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    steer_speed_checker steer_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmds_outstanding (cmds_outstanding),
        .mismatch_count   (mismatch_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run (~2 ms with every gap and stall long).
    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] rand_word();
        return CFG_DATA_BITS'({$urandom, $urandom});
    endfunction

    // Pack five samples, far left first.
    function automatic logic [IN_BITS-1:0] sensor_set(input int fl, input int nl, input int md,
                                                      input int nr, input int fr);
        return {SAMPLE_BITS'(fr), SAMPLE_BITS'(nr), SAMPLE_BITS'(md),
                SAMPLE_BITS'(nl), SAMPLE_BITS'(fl)};
    endfunction

    // Write one register; drop valid after the beat and leave an idle gap before the next.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_WHITE)
            cur_white = value;
        if (idx == CFG_DEADBAND)
            cur_db = value[DB_BITS-1:0];
        @(posedge aclk);
    endtask

    // Send one sensor beat. Valid stays high across back-to-back beats and is
    // only dropped when a gap is taken.
    task automatic send_set(input logic [IN_BITS-1:0] set);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= IN_TDATA_BITS'(set);
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Hold the sender until every predicted beat has come back, then let the
    // pipeline settle.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (cmds_outstanding != 0)
            @(posedge aclk);
        repeat (DRAIN_MARGIN) @(posedge aclk);
    endtask

    // Receiver: bursts of ready with stalls between, always ready while calm.
    initial begin
        wait (aresetn === 1'b1);
        forever begin
            if (calm) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
                m_tready <= 1'b0;
                repeat (1 + idle_len()) @(posedge aclk);
            end
        end
    end

    initial begin
        logic [CFG_DATA_BITS-1:0] word;
        logic [IN_BITS-1:0]       set;
        int                       mode, p, p2, w, dark, smp, c, t1;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, reset registers: white 1023, deadband 50, center 90 in 45..135.
        send_set(sensor_set(1023, 1023, 1023, 1023, 1023));  // nothing dark: no line
        send_set(sensor_set(0, 0, 0, 0, 0));                 // all dark: centered
        send_set(sensor_set(0, 1023, 1023, 1023, 1023));     // far left only
        send_set(sensor_set(1023, 1023, 1023, 1023, 0));     // far right only
        send_set(sensor_set(1023, 0, 1023, 1023, 1023));     // near left only
        send_set(sensor_set(1023, 1023, 1023, 0, 1023));     // near right only
        send_set(sensor_set(1023, 1023, 0, 1023, 1023));     // middle only
        send_set(sensor_set(973, 1023, 1023, 1023, 1023));   // darkness at deadband
        send_set(sensor_set(974, 1023, 1023, 1023, 1023));   // one below deadband
        send_set(sensor_set(1023, 1023, 600, 500, 1023));
        send_set(sensor_set(1023, 900, 600, 1023, 1023));
        // edges of the straight band: error 38 / 39, then -38 / -39
        send_set(sensor_set(1023, 1023, 153, 870, 1023));
        send_set(sensor_set(1023, 1023, 156, 867, 1023));
        send_set(sensor_set(1023, 870, 153, 1023, 1023));
        send_set(sensor_set(1023, 867, 156, 1023, 1023));
        // error magnitude 384 sits exactly on the level two threshold
        send_set(sensor_set(0, 0, 1023, 1023, 1023));
        send_set(sensor_set(1023, 1023, 1023, 0, 0));

        // Zero deadband with white at 500: zero darkness passes but totals zero,
        // and samples above white give negative darkness.
        wait_drain();
        write_reg(CFG_DEADBAND, '0);
        write_reg(CFG_WHITE, {SENSOR_COUNT{10'd500}});
        send_set(sensor_set(500, 500, 500, 500, 500));
        send_set(sensor_set(600, 600, 600, 600, 600));
        send_set(sensor_set(600, 600, 500, 600, 400));
        send_set(sensor_set(0, 1023, 1023, 1023, 1023));

        // Inverted limits: minimum 120 above maximum 60, center 90.
        wait_drain();
        write_reg(CFG_SERVO, CFG_DATA_BITS'({8'd60, 8'd120, 8'd90}));
        send_set(sensor_set(500, 500, 500, 500, 500));
        send_set(sensor_set(600, 600, 600, 600, 400));
        send_set(sensor_set(400, 600, 600, 600, 600));

        // Writes past the register list must leave everything as it was.
        wait_drain();
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, rand_word());
        send_set(sensor_set(500, 450, 500, 500, 500));

        // Random phases: restored defaults, all ones, all zeros, then shaped random.
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drain();
            case (ph)
                0: begin
                    write_reg(CFG_WHITE, '1);
                    write_reg(CFG_DEADBAND, CFG_DATA_BITS'(DEADBAND_RESET));
                    write_reg(CFG_SERVO, CFG_DATA_BITS'(SERVO_RESET));
                end
                1: begin
                    for (int k = CFG_WHITE; k <= CFG_SLOW_RATIO; k++)
                        write_reg(CFG_INDEX_BITS'(k), '1);
                end
                2: begin
                    for (int k = CFG_WHITE; k <= CFG_SLOW_RATIO; k++)
                        write_reg(CFG_INDEX_BITS'(k), '0);
                end
                default: begin
                    // white levels mostly high so lines stand out
                    word = '0;
                    for (int i = 0; i < SENSOR_COUNT; i++)
                        word[i*WHITE_BITS +: WHITE_BITS] = ($urandom_range(0, 99) < 70) ?
                            WHITE_BITS'($urandom_range(700, 1023)) :
                            WHITE_BITS'($urandom_range(0, 1023));
                    write_reg(CFG_WHITE, word);
                    // upper bits stay random to exercise field truncation
                    word = rand_word();
                    if ($urandom_range(0, 99) < 75)
                        word[DB_BITS-1:0] = DB_BITS'($urandom_range(0, 150));
                    write_reg(CFG_DEADBAND, word);
                    write_reg(CFG_KP, rand_word());
                    word = rand_word();
                    if ($urandom_range(0, 99) < 70) begin
                        c = $urandom_range(40, 140);
                        word[SERVO_BITS-1:0] = {ANGLE_BITS'($urandom_range(c, 180)),
                                                ANGLE_BITS'($urandom_range(0, c)),
                                                ANGLE_BITS'(c)};
                    end
                    write_reg(CFG_SERVO, word);
                    write_reg(CFG_BASE, rand_word());
                    write_reg(CFG_TURN, rand_word());
                    word = rand_word();
                    if ($urandom_range(0, 99) < 75) begin
                        t1 = $urandom_range(0, 400);
                        word[2*TH_BITS-1:0] = {TH_BITS'($urandom_range(t1, 600)), TH_BITS'(t1)};
                    end
                    write_reg(CFG_SLOW_TH, word);
                    write_reg(CFG_SLOW_RATIO, rand_word());
                    write_reg(CFG_SPARE_LO + CFG_INDEX_BITS'(ph), rand_word());
                end
            endcase

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                calm = (n >= 40 && n < 90);
                // once per phase, hold the sender until the pipeline is empty
                if (n == 150)
                    wait_drain();

                // Mostly a line under one or two adjacent sensors with random
                // neighbors and faint sensors beyond; some sets at or above white; the rest pure noise.
                mode = $urandom_range(0, 99);
                p    = $urandom_range(0, SENSOR_COUNT - 1);
                p2   = (p < SENSOR_COUNT - 1 && $urandom_range(0, 1) == 1) ? p + 1 : p;
                for (int i = 0; i < SENSOR_COUNT; i++) begin
                    w = int'(cur_white[i*WHITE_BITS +: WHITE_BITS]);
                    if (mode >= 85) begin
                        smp = $urandom_range(0, 1023);
                    end else begin
                        if (mode < 10)
                            dark = -int'($urandom_range(0, 60));
                        else if (i == p || i == p2)
                            dark = $urandom_range(int'(cur_db), 1023);
                        else if (i == p - 1 || i == p2 + 1)
                            dark = $urandom_range(0, 1023);
                        else begin
                            case ($urandom_range(0, 3))
                                0:       dark = int'(cur_db);
                                1:       dark = int'(cur_db) - 1;
                                default: dark = $urandom_range(0, int'(cur_db));
                            endcase
                        end
                        smp = w - dark;
                        if (smp < 0)
                            smp = 0;
                        else if (smp > 1023)
                            smp = 1023;
                    end
                    set[i*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'(smp);
                end
                send_set(set);
            end
        end
        calm = 1'b0;

        wait_drain();
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
